@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the sort engine RTL.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks a property at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/ise_pkg.sv @@
// Shared types and constants for the integer sort engine.
// No dependencies; used by ise_cell and integer_sort_engine_unit.
package ise_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    // Most negative value: a left neighbor holding it never blocks an insert.
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [CNT_W-1:0]        t_count;

    typedef struct packed {
        logic insert;  // broadcast value is placed into the ordered chain
        logic shift;   // chain moves one place toward the output
    } t_cell_ctl;

endpackage

@@ hw/rtl/integer_sort_engine_unit.sv @@
// Top level of the integer sort engine: a chain of ise_cell insertion cells
// plus the fill/drain controller. Depends on ise_pkg, ise_cell, assert_macros.svh.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+--------------------------------------------
//  input   | i_valid | o_stall | i_value, i_is_final
//  output  | o_valid | i_stall | o_sorted_value, o_end_of_run, o_overflowed
//
// Filling: one value per cycle, inserted in order across all cells at once.
// A final transaction starts the drain in the following cycle; the drain delivers
// one result per cycle from cell 0 while the chain shifts, unless i_stall is high.
// o_stall is high for the drain.
// Reset clears the valid bits of the chain; no clearing pass is needed.
// Output stalls simply hold the chain; nothing is lost or repeated.
module integer_sort_engine_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ise_pkg::t_value i_value,
    input  logic            i_is_final,
    output logic            o_valid,
    input  logic            i_stall,
    output ise_pkg::t_value o_sorted_value,
    output logic            o_end_of_run,
    output logic            o_overflowed
);
    import ise_pkg::*;

    `include "assert_macros.svh"

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic      r_state;
    logic      n_state;
    t_count    r_count;
    t_count    n_count;
    logic      r_drop;
    logic      n_drop;
    logic      w_in_take;
    logic      w_out_take;
    logic      w_full;
    t_cell_ctl w_ctl;

    t_value w_val [CAPACITY];
    logic   w_vld [CAPACITY];
    logic [CAPACITY-1:0] w_vld_vec;

    assign w_full     = (r_count == t_count'(CAPACITY));
    assign o_stall    = (r_state == ST_DRAIN);
    assign w_in_take  = i_valid && !o_stall;
    assign o_valid    = (r_state == ST_DRAIN) && w_vld[0];
    assign w_out_take = o_valid && !i_stall;

    assign w_ctl.insert = w_in_take && !w_full;
    assign w_ctl.shift  = w_out_take;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_value w_left_value;
            logic   w_left_valid;
            t_value w_right_value;
            logic   w_right_valid;

            if (g == 0) begin : g_head
                assign w_left_value = VAL_MIN;
                assign w_left_valid = 1'b1;
            end else begin : g_body
                assign w_left_value = w_val[g-1];
                assign w_left_valid = w_vld[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right_value = '0;
                assign w_right_valid = 1'b0;
            end else begin : g_next
                assign w_right_value = w_val[g+1];
                assign w_right_valid = w_vld[g+1];
            end

            ise_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_new_value   (i_value),
                .i_left_value  (w_left_value),
                .i_left_valid  (w_left_valid),
                .i_right_value (w_right_value),
                .i_right_valid (w_right_valid),
                .o_value       (w_val[g]),
                .o_valid       (w_vld[g])
            );

            assign w_vld_vec[g] = w_vld[g];
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        unique case (r_state)
            ST_FILL: begin
                if (w_in_take) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + t_count'(1);
                    end
                    if (i_is_final) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // The transaction that empties the chain closes the set.
                if (w_out_take && o_end_of_run) begin
                    n_state = ST_FILL;
                    n_count = '0;
                    n_drop  = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    assign o_sorted_value = w_val[0];
    assign o_end_of_run   = !w_vld[1];
    assign o_overflowed   = r_drop;

    `ASSERT_CLK(a_fill_count, (r_state == ST_FILL) |-> ($countones(w_vld_vec) == r_count), "chain occupancy differs from count")
    `ASSERT_CLK(a_final_drains, (w_in_take && i_is_final) |=> o_valid, "final transaction did not start the drain")
    `ASSERT_CLK(a_drain_continues, (w_out_take && !o_end_of_run) |=> o_valid, "drain stopped before the last result")
    `ASSERT_CLK(a_ordered_head, (o_valid && w_vld[1]) |-> (w_val[0] <= w_val[1]), "chain head is out of order")

endmodule

@@ hw/rtl/ise_cell.sv @@
// One cell of the insertion chain: holds one value and its valid bit.
// Depends on ise_pkg.
module ise_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ise_pkg::t_cell_ctl i_ctl,
    input  ise_pkg::t_value    i_new_value,
    input  ise_pkg::t_value    i_left_value,
    input  logic               i_left_valid,
    input  ise_pkg::t_value    i_right_value,
    input  logic               i_right_valid,
    output ise_pkg::t_value    o_value,
    output logic               o_valid
);
    import ise_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   r_valid;
    logic   n_valid;
    logic   w_new_below_mine;
    logic   w_new_below_left;

    assign w_new_below_mine = !r_valid || (i_new_value < r_value);
    assign w_new_below_left = !i_left_valid || (i_new_value < i_left_value);

    // The new value lands in the first cell that is empty or whose content exceeds it;
    // every cell from there on takes its left neighbor's content.
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        priority if (i_ctl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctl.insert && w_new_below_mine) begin
            if (w_new_below_left) begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end else begin
            n_value = r_value;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule
